>>> src/ucrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_pkg - shared types and constants
// Request codes, descriptor types, reply sources and the classified request
// record passed from the decoder to the executor.
// ----------------------------------------------------------------------------
package ucrr_pkg;

    // Number of string descriptors the device offers (clipped to STRING_SUPPORTED)
    localparam int STRING_COUNT = 3;
    // Strings actually backed by a length: 0 fixed, 1 and 2 from registers
    localparam int STRING_SUPPORTED = 3;
    localparam int STRING_LIMIT =
        (STRING_COUNT < STRING_SUPPORTED) ? STRING_COUNT : STRING_SUPPORTED;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Standard request codes
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

    // Recipients and request type
    localparam logic [4:0] RCP_DEVICE    = 5'd0;
    localparam logic [4:0] RCP_INTERFACE = 5'd1;
    localparam logic [1:0] TYPE_STANDARD = 2'd0;

    // Descriptor types (high byte of wValue)
    localparam logic [7:0] DT_DEVICE       = 8'd1;
    localparam logic [7:0] DT_CONFIG       = 8'd2;
    localparam logic [7:0] DT_STRING       = 8'd3;
    localparam logic [7:0] DT_QUALIFIER    = 8'd6;
    localparam logic [7:0] DT_OTHER_SPEED  = 8'd7;

    // Descriptor lengths
    localparam logic [7:0] LEN_DEVICE    = 8'd18;
    localparam logic [7:0] LEN_QUALIFIER = 8'd10;
    localparam logic [7:0] LEN_CONFIG    = 8'd55;
    localparam logic [7:0] LEN_STRING0   = 8'd4;
    localparam logic [7:0] LEN_ONE_BYTE  = 8'd1;

    // Reply sources
    localparam logic [2:0] SRC_NONE      = 3'd0;
    localparam logic [2:0] SRC_DEVICE    = 3'd1;
    localparam logic [2:0] SRC_QUALIFIER = 3'd2;
    localparam logic [2:0] SRC_CONFIG    = 3'd3;
    localparam logic [2:0] SRC_OTHER     = 3'd4;
    localparam logic [2:0] SRC_STRING    = 3'd5;
    localparam logic [2:0] SRC_ONE_BYTE  = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINK_HS     = 2'd0;
    localparam logic [1:0] CFG_MANUF_LEN   = 2'd1;
    localparam logic [1:0] CFG_PRODUCT_LEN = 2'd2;

    localparam logic [7:0] MANUF_LEN_RESET   = 8'd40;
    localparam logic [7:0] PRODUCT_LEN_RESET = 8'd46;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [3:0] {
        KIND_STALL,
        KIND_DESC_DEVICE,
        KIND_DESC_QUALIFIER,
        KIND_DESC_CONFIG,
        KIND_DESC_OTHER,
        KIND_DESC_STRING,
        KIND_GET_CONFIG,
        KIND_SET_CONFIG,
        KIND_GET_INTERFACE,
        KIND_SET_INTERFACE
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [1:0]  string_index;
        logic        config_value;
        logic [15:0] length_limit;
    } req_entry_t;

    typedef struct packed {
        logic       link_high_speed;
        logic [7:0] manufacturer_string_length;
        logic [7:0] product_string_length;
    } cfg_regs_t;

    typedef struct packed {
        logic       stall_res;
        logic [2:0] reply_source;
        logic       descriptor_set_high;
        logic [1:0] string_index;
        logic [7:0] reply_length;
        logic       reply_byte;
        logic       endpoints_enable;
        logic       endpoints_disable;
    } reply_t;

    // Descriptor length clipped to wLength
    function automatic logic [7:0] clip_len(input logic [7:0] len,
                                            input logic [15:0] limit);
        logic [7:0] r;
        if (limit < {8'h00, len})
            r = limit[7:0];
        else
            r = len;
        return r;
    endfunction

endpackage

>>> src/ucrr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_decode - setup packet classifier
// Checks type, recipient and request fields of a setup packet and reduces it
// to a request kind plus the few operands the executor needs.
// ----------------------------------------------------------------------------
module ucrr_decode
    import ucrr_pkg::*;
(
    input  logic [7:0]  request_type,
    input  logic [7:0]  request_code,
    input  logic [15:0] request_value,
    input  logic [15:0] request_index,
    input  logic [15:0] length_limit,
    output req_entry_t  entry
);

    logic [4:0] recip;
    logic [1:0] rtype;
    logic [7:0] dtype;
    logic [7:0] dindex;

    assign recip  = request_type[4:0];
    assign rtype  = request_type[6:5];
    assign dtype  = request_value[15:8];
    assign dindex = request_value[7:0];

    always_comb
    begin
        entry.kind         = KIND_STALL;
        entry.string_index = dindex[1:0];
        entry.config_value = request_value[0];
        entry.length_limit = length_limit;

        if (rtype == TYPE_STANDARD)
        begin
            if (request_code == REQ_GET_DESCRIPTOR && recip == RCP_DEVICE)
            begin
                if (dtype == DT_DEVICE)
                    entry.kind = KIND_DESC_DEVICE;
                else if (dtype == DT_QUALIFIER)
                    entry.kind = KIND_DESC_QUALIFIER;
                else if (dtype == DT_CONFIG)
                    entry.kind = KIND_DESC_CONFIG;
                else if (dtype == DT_OTHER_SPEED)
                    entry.kind = KIND_DESC_OTHER;
                else if (dtype == DT_STRING && dindex < 8'(STRING_LIMIT))
                    entry.kind = KIND_DESC_STRING;
            end
            else if (request_code == REQ_GET_CONFIGURATION && recip == RCP_DEVICE)
            begin
                entry.kind = KIND_GET_CONFIG;
            end
            else if (request_code == REQ_SET_CONFIGURATION && recip == RCP_DEVICE)
            begin
                // full 16-bit wValue must be 0 or 1
                if (request_value[15:1] == 15'd0)
                    entry.kind = KIND_SET_CONFIG;
            end
            else if (request_code == REQ_GET_INTERFACE && recip == RCP_INTERFACE)
            begin
                entry.kind = KIND_GET_INTERFACE;
            end
            else if (request_code == REQ_SET_INTERFACE && recip == RCP_INTERFACE)
            begin
                if (request_index[7:0] == 8'd0 && dindex == 8'd0)
                    entry.kind = KIND_SET_INTERFACE;
            end
        end
    end

endmodule

>>> src/ucrr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_queue - request queue
// Small FIFO of classified requests between the decoder and the executor.
// ----------------------------------------------------------------------------
module ucrr_queue
    import ucrr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  req_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output req_entry_t head
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    req_entry_t          mem [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> src/ucrr_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_execute - request executor
// Carries out a classified request: picks reply source, descriptor set and
// clipped length, keeps the current configuration, holds the result register.
// ----------------------------------------------------------------------------
module ucrr_execute
    import ucrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_regs_t  cfg,
    input  logic       q_empty,
    input  req_entry_t q_head,
    output logic       q_pop,
    output reply_t     result,
    output logic       result_valid,
    input  logic       result_ready
);

    logic   cur_config_reg, cur_config_next;
    logic   valid_reg;
    reply_t result_reg;
    reply_t reply_next;
    logic   take;

    // Result register frees up when empty or being drained this cycle
    assign take         = !valid_reg || result_ready;
    assign q_pop        = take && !q_empty;
    assign result       = result_reg;
    assign result_valid = valid_reg;

    always_comb
    begin
        reply_next      = '0;
        cur_config_next = cur_config_reg;
        case (q_head.kind)
            KIND_DESC_DEVICE:
            begin
                reply_next.reply_source        = SRC_DEVICE;
                reply_next.descriptor_set_high = cfg.link_high_speed;
                reply_next.reply_length        = clip_len(LEN_DEVICE, q_head.length_limit);
            end
            KIND_DESC_QUALIFIER:
            begin
                reply_next.reply_source        = SRC_QUALIFIER;
                reply_next.descriptor_set_high = cfg.link_high_speed;
                reply_next.reply_length = clip_len(LEN_QUALIFIER, q_head.length_limit);
            end
            KIND_DESC_CONFIG:
            begin
                reply_next.reply_source        = SRC_CONFIG;
                reply_next.descriptor_set_high = cfg.link_high_speed;
                reply_next.reply_length        = clip_len(LEN_CONFIG, q_head.length_limit);
            end
            KIND_DESC_OTHER:
            begin
                // other speed's configuration descriptor
                reply_next.reply_source        = SRC_OTHER;
                reply_next.descriptor_set_high = !cfg.link_high_speed;
                reply_next.reply_length        = clip_len(LEN_CONFIG, q_head.length_limit);
            end
            KIND_DESC_STRING:
            begin
                reply_next.reply_source = SRC_STRING;
                reply_next.string_index = q_head.string_index;
                case (q_head.string_index)
                    2'd0:    reply_next.reply_length =
                                 clip_len(LEN_STRING0, q_head.length_limit);
                    2'd1:    reply_next.reply_length =
                                 clip_len(cfg.manufacturer_string_length,
                                          q_head.length_limit);
                    default: reply_next.reply_length =
                                 clip_len(cfg.product_string_length,
                                          q_head.length_limit);
                endcase
            end
            KIND_GET_CONFIG:
            begin
                reply_next.reply_source = SRC_ONE_BYTE;
                reply_next.reply_byte   = cur_config_reg;
                reply_next.reply_length = clip_len(LEN_ONE_BYTE, q_head.length_limit);
            end
            KIND_SET_CONFIG:
            begin
                cur_config_next              = q_head.config_value;
                reply_next.endpoints_enable  = q_head.config_value;
                reply_next.endpoints_disable = !q_head.config_value;
            end
            KIND_GET_INTERFACE:
            begin
                reply_next.reply_source = SRC_ONE_BYTE;
                reply_next.reply_length = clip_len(LEN_ONE_BYTE, q_head.length_limit);
            end
            KIND_SET_INTERFACE:
            begin
                reply_next = '0;
            end
            default:
            begin
                reply_next.stall_res = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            cur_config_reg <= 1'b0;
        end
        else
        begin
            if (take)
                valid_reg <= !q_empty;
            if (q_pop)
                cur_config_reg <= cur_config_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            result_reg <= reply_next;
    end

endmodule

>>> src/usb_control_request_responder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_control_request_responder_top - USB standard request responder
// Decodes setup packets and answers standard device requests for endpoint 0.
// ----------------------------------------------------------------------------
// Accepts one setup packet per cycle while the request queue is not full and
// returns one reply per packet, in order. A packet is registered in the request
// queue, then its reply in the result register, which drives the master side.
// The decoder feeds a QUEUE_DEPTH-entry queue and the executor drains one
// entry per cycle, so throughput is one transaction per clock while the
// master side keeps tready high. Configuration writes take effect at once and
// are meant for idle periods only.
module usb_control_request_responder_top
    import ucrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // setup packet stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] request_type, [15:8] request_code, [31:16] request_value,
    // [47:32] request_index, [63:48] length_limit
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // reply stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] stall_res, [3:1] reply_source, [4] descriptor_set_high,
    // [6:5] string_index, [14:7] reply_length, [15] reply_byte,
    // [16] endpoints_enable, [17] endpoints_disable, [23:18] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);

    cfg_regs_t  cfg_reg;
    req_entry_t dec_entry;
    req_entry_t q_head;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    reply_t     result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_high_speed            <= 1'b0;
            cfg_reg.manufacturer_string_length <= MANUF_LEN_RESET;
            cfg_reg.product_string_length      <= PRODUCT_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINK_HS:     cfg_reg.link_high_speed            <= cfg_data[0];
                CFG_MANUF_LEN:   cfg_reg.manufacturer_string_length <= cfg_data;
                CFG_PRODUCT_LEN: cfg_reg.product_string_length      <= cfg_data;
                default:         ;
            endcase
        end
    end

    ucrr_decode u_decode (
        .request_type  (s_tdata[7:0]),
        .request_code  (s_tdata[15:8]),
        .request_value (s_tdata[31:16]),
        .request_index (s_tdata[47:32]),
        .length_limit  (s_tdata[63:48]),
        .entry         (dec_entry)
    );

    assign s_tready = !q_full;

    ucrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_entry (dec_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    ucrr_execute u_execute (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result       (result),
        .result_valid (m_tvalid),
        .result_ready (m_tready)
    );

    assign m_tdata = {6'd0,
                      result.endpoints_disable,
                      result.endpoints_enable,
                      result.reply_byte,
                      result.reply_length,
                      result.string_index,
                      result.descriptor_set_high,
                      result.reply_source,
                      result.stall_res};

endmodule
